// ===== hw/rtl/gstuf_pkg.sv =====
// ----------------------------------------------------------------------------
// gstuf_pkg
// Shared sizes, direction codes, state and command types for the grid
// spanning-tree builder.
// ----------------------------------------------------------------------------
package gstuf_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int CELL_COUNT = MAX_WIDTH * MAX_HEIGHT;
    localparam int CELL_W     = $clog2(CELL_COUNT);
    localparam int LINK_W     = CELL_W + 1;      // root flag on top of the parent index
    localparam int COORD_W    = 6;
    localparam int GRID_W     = 7;
    localparam int DIM_W      = 9;               // holds MAX_WIDTH / MAX_HEIGHT up to 256
    localparam int MASK_W     = 4;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_GRID_WIDTH  = 3'd0;
    localparam logic [APB_ADDR_W-1:0] ADDR_GRID_HEIGHT = 3'd4;

    localparam logic [MASK_W-1:0] DIR_N = 4'b0001;
    localparam logic [MASK_W-1:0] DIR_E = 4'b0010;
    localparam logic [MASK_W-1:0] DIR_S = 4'b0100;
    localparam logic [MASK_W-1:0] DIR_W = 4'b1000;

    localparam logic EDGE_WEST  = 1'b0;
    localparam logic EDGE_NORTH = 1'b1;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_WALK_A,
        ST_WALK_B,
        ST_LINK,
        ST_MASK_A,
        ST_MASK_B,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        RD_HOLD,
        RD_HERE,
        RD_THERE,
        RD_LINK
    } rd_sel_t;

    typedef struct packed {
        logic    clear_step;
        logic    latch_in;
        rd_sel_t rd_sel;
        logic    save_root_a;
        logic    link;
        logic    mask_rd_here;
        logic    mask_wr_here;
        logic    mask_wr_there;
        logic    out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic reject;
        logic link_is_root;
    } dp_stat_t;

endpackage

// ===== hw/rtl/gstuf_ram.sv =====
// ----------------------------------------------------------------------------
// gstuf_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module gstuf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/gstuf_dp.sv =====
// ----------------------------------------------------------------------------
// gstuf_dp
// Datapath: edge registers, parent-link and passage memories, walk pointer,
// clearing counter and result register.
// ----------------------------------------------------------------------------
module gstuf_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  gstuf_pkg::dp_cmd_t             cmd,
    output gstuf_pkg::dp_stat_t            stat,
    input  logic [gstuf_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [gstuf_pkg::GRID_W-1:0]   grid_width,
    input  logic [gstuf_pkg::GRID_W-1:0]   grid_height,
    output logic [gstuf_pkg::M_DATA_W-1:0] m_tdata
);
    import gstuf_pkg::*;

    logic [COORD_W-1:0] x_reg, y_reg;
    logic               dir_reg;
    logic [CELL_W-1:0]  here, there;
    logic [DIM_W-1:0]   w_eff, h_eff, x_ext, y_ext;
    logic               reject;

    logic [CELL_W-1:0]  clr_cnt_reg;
    logic [CELL_W-1:0]  cur_reg, root_a_reg;
    logic               joined_reg;
    logic               roots_differ;

    logic               p_we;
    logic [CELL_W-1:0]  p_waddr, p_raddr;
    logic [LINK_W-1:0]  p_wdata, p_rdata;

    logic               m_we;
    logic [CELL_W-1:0]  m_waddr, m_raddr;
    logic [MASK_W-1:0]  m_wdata, m_rdata;
    logic [MASK_W-1:0]  bit_here, bit_there, new_here, new_there;
    logic [MASK_W-1:0]  here_dirs_reg, there_dirs_reg;

    logic               out_rejected_reg, out_joined_reg;
    logic [MASK_W-1:0]  out_here_reg, out_there_reg;

    // latch the edge
    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            x_reg   <= s_tdata[COORD_W-1:0];
            y_reg   <= s_tdata[2*COORD_W-1:COORD_W];
            dir_reg <= s_tdata[2*COORD_W];
        end
    end

    // bounds check against the usable grid
    assign x_ext = DIM_W'(x_reg);
    assign y_ext = DIM_W'(y_reg);
    assign w_eff = (DIM_W'(grid_width) < DIM_W'(MAX_WIDTH)) ? DIM_W'(grid_width)
                                                             : DIM_W'(MAX_WIDTH);
    assign h_eff = (DIM_W'(grid_height) < DIM_W'(MAX_HEIGHT)) ? DIM_W'(grid_height)
                                                               : DIM_W'(MAX_HEIGHT);
    assign reject = (x_ext >= w_eff) || (y_ext >= h_eff) ||
                    ((dir_reg == EDGE_NORTH) ? (y_reg == '0) : (x_reg == '0));

    assign here  = CELL_W'(y_reg) * CELL_W'(MAX_WIDTH) + CELL_W'(x_reg);
    assign there = (dir_reg == EDGE_NORTH) ? here - CELL_W'(MAX_WIDTH) : here - CELL_W'(1);

    // clearing counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + CELL_W'(1);
        end
    end

    // parent-link walk
    always_comb begin
        case (cmd.rd_sel)
            RD_HERE:  p_raddr = here;
            RD_THERE: p_raddr = there;
            RD_LINK:  p_raddr = p_rdata[CELL_W-1:0];
            default:  p_raddr = cur_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_sel != RD_HOLD) begin
            cur_reg <= p_raddr;
        end
        if (cmd.save_root_a) begin
            root_a_reg <= cur_reg;
        end
        if (cmd.link) begin
            joined_reg <= roots_differ;
        end
    end

    // cur_reg holds the neighbor's root while linking
    assign roots_differ = (root_a_reg != cur_reg);

    assign p_we    = cmd.clear_step || (cmd.link && roots_differ);
    assign p_waddr = cmd.clear_step ? clr_cnt_reg : cur_reg;
    assign p_wdata = cmd.clear_step ? {1'b1, {CELL_W{1'b0}}} : {1'b0, here};

    gstuf_ram #(
        .WIDTH (LINK_W),
        .DEPTH (CELL_COUNT)
    ) u_parent_ram (
        .aclk  (aclk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    // passage masks
    assign bit_here  = (dir_reg == EDGE_NORTH) ? DIR_N : DIR_W;
    assign bit_there = (dir_reg == EDGE_NORTH) ? DIR_S : DIR_E;
    assign new_here  = m_rdata | (joined_reg ? bit_here : '0);
    assign new_there = m_rdata | (joined_reg ? bit_there : '0);

    assign m_raddr = cmd.mask_rd_here ? here : there;
    assign m_we    = cmd.clear_step || cmd.mask_wr_here || cmd.mask_wr_there;

    always_comb begin
        if (cmd.clear_step) begin
            m_waddr = clr_cnt_reg;
            m_wdata = '0;
        end else if (cmd.mask_wr_here) begin
            m_waddr = here;
            m_wdata = new_here;
        end else begin
            m_waddr = there;
            m_wdata = new_there;
        end
    end

    gstuf_ram #(
        .WIDTH (MASK_W),
        .DEPTH (CELL_COUNT)
    ) u_passage_ram (
        .aclk  (aclk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    always_ff @(posedge aclk) begin
        if (cmd.mask_wr_here) begin
            here_dirs_reg <= new_here;
        end
        if (cmd.mask_wr_there) begin
            there_dirs_reg <= new_there;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_rejected_reg <= reject;
            out_joined_reg   <= !reject && joined_reg;
            out_here_reg     <= reject ? '0 : here_dirs_reg;
            out_there_reg    <= reject ? '0 : there_dirs_reg;
        end
    end

    assign m_tdata = {{(M_DATA_W - 2 - 2*MASK_W){1'b0}},
                      out_there_reg, out_here_reg, out_joined_reg, out_rejected_reg};

    assign stat.clear_done   = (clr_cnt_reg == CELL_W'(CELL_COUNT - 1));
    assign stat.reject       = reject;
    assign stat.link_is_root = p_rdata[CELL_W];

endmodule

// ===== hw/rtl/gstuf_ctrl.sv =====
// ----------------------------------------------------------------------------
// gstuf_ctrl
// Sequencer: clearing pass, two root walks, link, mask update, result hand-off.
// ----------------------------------------------------------------------------
module gstuf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output gstuf_pkg::dp_cmd_t  cmd,
    input  gstuf_pkg::dp_stat_t stat
);
    import gstuf_pkg::*;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_HOLD;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                cmd.latch_in = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (stat.reject) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.rd_sel = RD_HERE;
                    state_next = ST_WALK_A;
                end
            end
            ST_WALK_A: begin
                if (stat.link_is_root) begin
                    cmd.save_root_a = 1'b1;
                    cmd.rd_sel      = RD_THERE;
                    state_next      = ST_WALK_B;
                end else begin
                    cmd.rd_sel = RD_LINK;
                end
            end
            ST_WALK_B: begin
                if (stat.link_is_root) begin
                    state_next = ST_LINK;
                end else begin
                    cmd.rd_sel = RD_LINK;
                end
            end
            ST_LINK: begin
                cmd.link         = 1'b1;
                cmd.mask_rd_here = 1'b1;
                state_next       = ST_MASK_A;
            end
            ST_MASK_A: begin
                cmd.mask_wr_here = 1'b1;
                state_next       = ST_MASK_B;
            end
            ST_MASK_B: begin
                cmd.mask_wr_there = 1'b1;
                state_next        = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

// ===== hw/rtl/grid_spanning_tree_union_find.sv =====
// ----------------------------------------------------------------------------
// grid_spanning_tree_union_find
// Maze carving by union-find over a grid: one edge word in, one result out.
// ----------------------------------------------------------------------------
// Each input word names a cell and an edge toward its west or north neighbor.
// The block follows parent links from both cells to their roots through a
// single parent-link memory, one link per cycle; if the roots differ it hangs
// the neighbor's root under the edge's own cell and opens the passage bits in
// both cells' masks, then loads the result word. An edge that leaves the
// configured grid goes straight to the result word and changes nothing.
// After reset the block sweeps both memories, one cell per cycle, over all
// 4096 cells (MAX_WIDTH * MAX_HEIGHT) and takes no edge until the sweep is
// done; the APB registers are writable throughout. Write grid_width and
// grid_height only while no edge is in flight.
// ----------------------------------------------------------------------------
module grid_spanning_tree_union_find (
    input  logic                             aclk,
    input  logic                             aresetn,
    // input edge words
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: cell_x[5:0], cell_y[11:6], edge_dir[12], zero pad [15:13]
    input  logic [gstuf_pkg::S_DATA_W-1:0]   s_tdata,
    // result words
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: rejected[0], joined[1], here_dirs[5:2], neighbor_dirs[9:6],
    //          zero pad [15:10]
    output logic [gstuf_pkg::M_DATA_W-1:0]   m_tdata,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gstuf_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [gstuf_pkg::APB_DATA_W-1:0] pwdata,
    output logic [gstuf_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready
);
    import gstuf_pkg::*;

    logic [GRID_W-1:0] grid_width_reg, grid_height_reg;
    logic              cfg_wr;
    dp_cmd_t           cmd;
    dp_stat_t          stat;

    // register file: always ready, write in the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= GRID_W'(64);
            grid_height_reg <= GRID_W'(64);
        end else if (cfg_wr) begin
            case (paddr)
                ADDR_GRID_WIDTH:  grid_width_reg  <= pwdata[GRID_W-1:0];
                ADDR_GRID_HEIGHT: grid_height_reg <= pwdata[GRID_W-1:0];
                default:          ;  // drop writes to unmapped addresses
            endcase
        end
    end

    always_comb begin
        case (paddr)
            ADDR_GRID_WIDTH:  prdata = APB_DATA_W'(grid_width_reg);
            ADDR_GRID_HEIGHT: prdata = APB_DATA_W'(grid_height_reg);
            default:          prdata = '0;
        endcase
    end

    // sequencer
    gstuf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // memories, walk pointer and result register
    gstuf_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .grid_width  (grid_width_reg),
        .grid_height (grid_height_reg),
        .m_tdata     (m_tdata)
    );

endmodule

// ===== dv/tb_grid_spanning_tree_union_find.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_spanning_tree_union_find
// Self-checking bench for the union-find maze carver.
// ----------------------------------------------------------------------------
// Feeds wall words (cell, west or north) through the input stream and checks
// every result word against an in-bench union-find model. The model keeps its
// own parent links, passage masks and grid size. The run covers a directed
// set of corner cases on the reset grid, empty and one-wide grids, an
// oversize grid, and full shuffled wall lists of growing mazes with noise
// mixed in. Both stream sides idle at random, and the result side holds off
// once for a long stretch to back the block up.
// ----------------------------------------------------------------------------
module tb_grid_spanning_tree_union_find;

    import gstuf_pkg::*;

    localparam int CYCLE_LIMIT  = 12_000_000;
    localparam int STALL_AT     = 300;    // results seen before the long hold-off
    localparam int STALL_CYCLES = 400;
    localparam int DRAIN_CYCLES = 50;
    localparam int PRINT_CAP    = 100;

    // One wall word: cell_x in the low bits, then cell_y, then edge_dir.
    typedef struct packed {
        logic               dir;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } wall_t;

    // One result word: rejected in bit 0, then joined, here_dirs, neighbor_dirs.
    typedef struct packed {
        logic [MASK_W-1:0] neighbor_dirs;
        logic [MASK_W-1:0] here_dirs;
        logic              joined;
        logic              rejected;
    } carve_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    grid_spanning_tree_union_find dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Union-find model: parent links, passage masks and the grid size in use
    // ------------------------------------------------------------------------
    logic [LINK_W-1:0] tree_link [CELL_COUNT];   // top bit marks a root
    logic [MASK_W-1:0] cell_open [CELL_COUNT];
    logic [GRID_W-1:0] grid_cols;
    logic [GRID_W-1:0] grid_rows;

    wall_t  wall_queue [$];      // words waiting for the driver
    carve_t carve_expect [$];    // results owed by the block, oldest first

    int  walls_issued   = 0;
    int  walls_accepted = 0;
    int  results_seen   = 0;
    int  mismatches     = 0;
    int  cycle_count    = 0;
    bit  s_taken        = 1'b0;
    bit  m_taken        = 1'b0;
    bit  s_rush         = 1'b0;
    bit  m_rush         = 1'b0;
    bit  stall_done     = 1'b0;
    int  s_idle_left    = 0;
    int  m_idle_left    = 0;
    int  stall_left     = 0;

    function automatic int unsigned root_of(int unsigned start_cell);
        int unsigned cur;
        cur = start_cell;
        // Bound the walk by the store size.
        for (int unsigned n = 0; n < CELL_COUNT; n++) begin
            if (tree_link[cur][LINK_W-1])
                break;
            cur = tree_link[cur][CELL_W-1:0];
        end
        return cur;
    endfunction

    // Apply one wall to the model and return the result word it must give.
    function automatic carve_t carve_wall(wall_t wl);
        carve_t      r;
        int unsigned cols, rows, here, there, root_here, root_there;
        cols = (grid_cols < MAX_WIDTH)  ? grid_cols : MAX_WIDTH;
        rows = (grid_rows < MAX_HEIGHT) ? grid_rows : MAX_HEIGHT;
        r = '0;
        // Reject a cell outside the grid, or a neighbor across the top or left rim.
        if (wl.x >= cols || wl.y >= rows ||
            ((wl.dir == EDGE_NORTH) ? (wl.y == 0) : (wl.x == 0))) begin
            r.rejected = 1'b1;
            return r;
        end
        here  = wl.y * MAX_WIDTH + wl.x;
        there = (wl.dir == EDGE_NORTH) ? here - MAX_WIDTH : here - 1;
        root_here  = root_of(here);
        root_there = root_of(there);
        if (root_here != root_there) begin
            // Hang the neighbor's root under the cell itself, not its root.
            tree_link[root_there] = {1'b0, CELL_W'(here)};
            if (wl.dir == EDGE_NORTH) begin
                cell_open[here]  = cell_open[here]  | DIR_N;
                cell_open[there] = cell_open[there] | DIR_S;
            end else begin
                cell_open[here]  = cell_open[here]  | DIR_W;
                cell_open[there] = cell_open[there] | DIR_E;
            end
            r.joined = 1'b1;
        end
        r.here_dirs     = cell_open[here];
        r.neighbor_dirs = cell_open[there];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Draw the idle cycles before the next word; toggle into and out of
    // stretches with no idling at all.
    function automatic int idle_draw(inout bit rush);
        if ($urandom_range(0, 31) == 0)
            rush = !rush;
        return rush ? 0 : int'($urandom_range(0, 15));
    endfunction

    // ------------------------------------------------------------------------
    // Sample both handshakes at the rising edge: check results, predict words
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        carve_t got;
        carve_t want;
        cycle_count++;
        if (aresetn) begin
            // Check the result first; a word accepted now cannot answer yet.
            if (m_tvalid && m_tready) begin
                got = carve_t'(m_tdata[$bits(carve_t)-1:0]);
                results_seen++;
                m_taken = 1'b1;
                if (carve_expect.size() == 0) begin
                    report_mismatch("result with nothing owed", got, 0);
                end else begin
                    want = carve_expect.pop_front();
                    if (got.rejected !== want.rejected)
                        report_mismatch("rejected", got.rejected, want.rejected);
                    if (got.joined !== want.joined)
                        report_mismatch("joined", got.joined, want.joined);
                    if (got.here_dirs !== want.here_dirs)
                        report_mismatch("here_dirs", got.here_dirs, want.here_dirs);
                    if (got.neighbor_dirs !== want.neighbor_dirs)
                        report_mismatch("neighbor_dirs", got.neighbor_dirs,
                                        want.neighbor_dirs);
                end
                if (m_tdata[M_DATA_W-1:$bits(carve_t)] !== '0)
                    report_mismatch("result pad", m_tdata[M_DATA_W-1:$bits(carve_t)], 0);
            end
            if (s_tvalid && s_tready) begin
                carve_expect.push_back(carve_wall(wall_t'(s_tdata[$bits(wall_t)-1:0])));
                walls_accepted++;
                s_taken = 1'b1;
            end
        end
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Wall driver: hold a word until taken, idle, then present the next one
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (s_tvalid && !s_taken) begin
            // hold the word until the block takes it
        end else begin
            s_taken = 1'b0;
            if (s_idle_left > 0) begin
                s_idle_left--;
                s_tvalid <= 1'b0;
            end else if (wall_queue.size() != 0) begin
                s_tdata     <= {{(S_DATA_W-$bits(wall_t)){1'b0}}, wall_queue.pop_front()};
                s_tvalid    <= 1'b1;
                s_idle_left = idle_draw(s_rush);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: idle after each word; once, hold off long enough that
    // the block fills up and stops taking walls
    // ------------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_taken) begin
                m_taken     = 1'b0;
                m_idle_left = idle_draw(m_rush);
            end
            if (!stall_done && results_seen >= STALL_AT) begin
                stall_done = 1'b1;
                stall_left = STALL_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (m_idle_left > 0) begin
                m_idle_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic wall_t make_wall(int unsigned x, int unsigned y, logic dir);
        wall_t wl;
        wl.x   = COORD_W'(x);
        wl.y   = COORD_W'(y);
        wl.dir = dir;
        return wl;
    endfunction

    task automatic queue_wall(input wall_t wl);
        wall_queue.push_back(wl);
        walls_issued++;
    endtask

    // Queue walls with coordinates drawn up to the given bounds.
    task automatic scatter(input int n, input int unsigned xmax, input int unsigned ymax);
        for (int i = 0; i < n; i++)
            queue_wall(make_wall($urandom_range(0, xmax), $urandom_range(0, ymax),
                                 logic'($urandom_range(0, 1))));
    endtask

    // Queue every inner wall of a cols x rows maze in shuffled order, with
    // the odd stray word mixed in.
    task automatic carve_maze(input int unsigned cols, input int unsigned rows);
        wall_t walls [$];
        wall_t tmp;
        int    j;
        for (int unsigned y = 0; y < rows; y++) begin
            for (int unsigned x = 0; x < cols; x++) begin
                if (x > 0) walls.push_back(make_wall(x, y, EDGE_WEST));
                if (y > 0) walls.push_back(make_wall(x, y, EDGE_NORTH));
            end
        end
        for (int i = walls.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = walls[i];
            walls[i] = walls[j];
            walls[j] = tmp;
        end
        foreach (walls[i]) begin
            if ($urandom_range(0, 9) == 0)
                scatter(1, MAX_WIDTH - 1, MAX_HEIGHT - 1);
            queue_wall(walls[i]);
        end
    endtask

    // Wait until every word is taken and every result is back.
    task automatic wait_drained();
        while (walls_accepted != walls_issued || carve_expect.size() != 0)
            @(negedge aclk);
    endtask

    // Write a register, then read it back.
    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== data)
            report_mismatch("register readback", prdata, data);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain, then resize the grid; the store keeps its links.
    task automatic next_grid(input int unsigned cols, input int unsigned rows);
        wait_drained();
        apb_write(ADDR_GRID_WIDTH, APB_DATA_W'(cols));
        grid_cols = GRID_W'(cols);
        apb_write(ADDR_GRID_HEIGHT, APB_DATA_W'(rows));
        grid_rows = GRID_W'(rows);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned cols;
        int unsigned rows;
        for (int i = 0; i < CELL_COUNT; i++) begin
            tree_link[i] = {1'b1, {CELL_W{1'b0}}};
            cell_open[i] = '0;
        end
        grid_cols = GRID_W'(MAX_WIDTH);
        grid_rows = GRID_W'(MAX_HEIGHT);
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed walls on the reset grid: rim rejects first.
        queue_wall(make_wall(0, 0, EDGE_WEST));
        queue_wall(make_wall(0, 0, EDGE_NORTH));
        queue_wall(make_wall(5, 0, EDGE_NORTH));
        queue_wall(make_wall(0, 5, EDGE_WEST));
        queue_wall(make_wall(63, 0, EDGE_NORTH));
        queue_wall(make_wall(0, 63, EDGE_WEST));
        // Close a loop in the top-left corner; the last two find one set.
        queue_wall(make_wall(1, 0, EDGE_WEST));
        queue_wall(make_wall(0, 1, EDGE_NORTH));
        queue_wall(make_wall(1, 1, EDGE_WEST));
        queue_wall(make_wall(1, 1, EDGE_NORTH));
        queue_wall(make_wall(1, 0, EDGE_WEST));
        // Grow the corner set so later walks follow longer chains.
        queue_wall(make_wall(2, 1, EDGE_WEST));
        queue_wall(make_wall(3, 1, EDGE_WEST));
        queue_wall(make_wall(2, 2, EDGE_NORTH));
        // Same loop at the far corner.
        queue_wall(make_wall(63, 63, EDGE_WEST));
        queue_wall(make_wall(63, 63, EDGE_NORTH));
        queue_wall(make_wall(63, 62, EDGE_WEST));
        queue_wall(make_wall(62, 63, EDGE_NORTH));
        // Remaining extremes and alternating bit patterns.
        queue_wall(make_wall(63, 0, EDGE_WEST));
        queue_wall(make_wall(0, 63, EDGE_NORTH));
        queue_wall(make_wall(42, 21, EDGE_WEST));
        queue_wall(make_wall(21, 42, EDGE_NORTH));
        queue_wall(make_wall(42, 42, EDGE_NORTH));
        queue_wall(make_wall(21, 21, EDGE_WEST));

        // Small full maze over the corner already touched.
        next_grid(4, 4);
        carve_maze(4, 4);

        // Empty grids reject everything.
        next_grid(0, 5);
        scatter(10, MAX_WIDTH - 1, MAX_HEIGHT - 1);
        next_grid(5, 0);
        scatter(10, MAX_WIDTH - 1, MAX_HEIGHT - 1);

        // One-wide and one-high grids.
        next_grid(1, 64);
        scatter(15, 1, MAX_HEIGHT - 1);
        next_grid(64, 1);
        scatter(15, MAX_WIDTH - 1, 1);

        // Oversize setting clamps to the full store.
        next_grid(127, 127);
        scatter(100, MAX_WIDTH - 1, MAX_HEIGHT - 1);

        // Growing mazes; each spans cells the last ones left apart.
        cols = $urandom_range(6, 9);
        rows = $urandom_range(5, 8);
        next_grid(cols, rows);
        carve_maze(cols, rows);
        next_grid(12, 10);
        carve_maze(12, 10);
        cols = $urandom_range(18, 22);
        rows = $urandom_range(14, 17);
        next_grid(cols, rows);
        carve_maze(cols, rows);

        // Full grid again, fresh cells still joining.
        next_grid(64, 64);
        scatter(150, MAX_WIDTH - 1, MAX_HEIGHT - 1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && carve_expect.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== grid_spanning_tree_union_find.f =====
hw/rtl/gstuf_pkg.sv
hw/rtl/gstuf_ram.sv
hw/rtl/gstuf_dp.sv
hw/rtl/gstuf_ctrl.sv
hw/rtl/grid_spanning_tree_union_find.sv
dv/tb_grid_spanning_tree_union_find.sv
